// ===== rtl/bcd_pkg.sv =====
`timescale 1ns / 1ps

package bcd_pkg;

  // Q16.16 data path widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned WGT_W  = 17;  // area weight, 0x10000 is 1.0
  localparam int unsigned DENS_W = 48;  // scaled current density

  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ENABLE = 3'd5;

  // request kinds
  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // one cell update issued to the update pipeline
  typedef struct packed {
    logic             valid;
    logic [1:0]       slot;   // bit 0: column +1, bit 1: row +1
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wz;
  } cell_req_t;

  // one finished cell write from the update pipeline
  typedef struct packed {
    logic              valid;
    logic [1:0]        slot;
    logic [DATA_W-1:0] value;
  } cell_wr_t;

endpackage

// ===== rtl/bcd_grid_mem.sv =====
`timescale 1ns / 1ps

module bcd_grid_mem #(
  parameter int unsigned DEPTH  = 4225,
  parameter int unsigned ADDR_W = 13
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [bcd_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [bcd_pkg::DATA_W-1:0] rdata_o
);

  logic [bcd_pkg::DATA_W-1:0] mem [DEPTH];
  logic [bcd_pkg::DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bcd_cell_update.sv =====
`timescale 1ns / 1ps

module bcd_cell_update #(
  parameter int unsigned ADDR_W = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [bcd_pkg::DENS_W-1:0] dens_i,
  input  bcd_pkg::cell_req_t                req_i,
  input  logic [ADDR_W-1:0]                 req_addr_i,
  output logic                              rd_en_o,
  output logic [ADDR_W-1:0]                 rd_addr_o,
  input  logic [bcd_pkg::DATA_W-1:0]        rd_data_i,
  output bcd_pkg::cell_wr_t                 wr_o,
  output logic [ADDR_W-1:0]                 wr_addr_o,
  output logic                              busy_o
);

  localparam int unsigned PROD_W = bcd_pkg::DENS_W + bcd_pkg::WGT_W + 1;
  localparam int unsigned SUM_W  = bcd_pkg::DENS_W + 1;

  logic                              s1_valid_q;
  logic [1:0]                        s1_slot_q;
  logic [ADDR_W-1:0]                 s1_addr_q;
  logic [bcd_pkg::WGT_W-1:0]         s1_wz_q;
  logic signed [bcd_pkg::DENS_W-1:0] s1_t_q;

  logic                              s2_valid_q;
  logic [1:0]                        s2_slot_q;
  logic [ADDR_W-1:0]                 s2_addr_q;
  logic signed [bcd_pkg::DENS_W-1:0] s2_u_q;

  logic signed [PROD_W-1:0] t_prod;
  logic signed [PROD_W-1:0] u_prod;
  logic signed [SUM_W-1:0]  sum;
  logic [bcd_pkg::DATA_W-1:0] sat;

  // stage 1: density times x weight, floor by dropping the low bits
  assign t_prod = dens_i * $signed({1'b0, req_i.wx});
  // stage 2: times z weight; the cell read goes out in parallel
  assign u_prod = s1_t_q * $signed({1'b0, s1_wz_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q <= req_i.slot;
    s1_addr_q <= req_addr_i;
    s1_wz_q   <= req_i.wz;
    s1_t_q    <= t_prod[bcd_pkg::FRAC_W +: bcd_pkg::DENS_W];
    s2_slot_q <= s1_slot_q;
    s2_addr_q <= s1_addr_q;
    s2_u_q    <= u_prod[bcd_pkg::FRAC_W +: bcd_pkg::DENS_W];
  end

  assign rd_en_o   = s1_valid_q;
  assign rd_addr_o = s1_addr_q;

  // stage 3: add to the old cell and saturate to 32 bits
  assign sum = SUM_W'(s2_u_q) + SUM_W'($signed(rd_data_i));

  always_comb begin
    if ((&sum[SUM_W-1:bcd_pkg::DATA_W-1]) || !(|sum[SUM_W-1:bcd_pkg::DATA_W-1])) begin
      sat = sum[bcd_pkg::DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(bcd_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(bcd_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign wr_o.valid = s2_valid_q;
  assign wr_o.slot  = s2_slot_q;
  assign wr_o.value = sat;
  assign wr_addr_o  = s2_addr_q;
  assign busy_o     = s1_valid_q || s2_valid_q;

endmodule

// ===== rtl/bilinear_current_deposit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o kind, position, current, read cell
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i deposited flag, cell value
// cfg       in         cfg_we_i (always taken)         register index and data
//
// A read request passes through the read step and the done step; a deposit runs
// through the shared 33x33 locate multiplier (three passes), the four
// read-modify-write cell updates through the single grid memory write port
// and, with mirror copies, four mirror writes on that same port.
// After reset all (GRID_N+1)^2 cells (4225 at the default) are cleared one cell
// a cycle, while no request is taken. The next request is taken while
// a result waits in the output register; a deposit finishing into a full
// output register waits there.

module bilinear_current_deposit #(
  parameter int unsigned GRID_N = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // pos_x, pos_z, filament_current, read_col, read_row (low bits first)
  input  logic [((3*bcd_pkg::DATA_W + 2*$clog2(GRID_N+1) + 7)/8)*8-1:0] s_axis_tdata_i,
  // kind
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // cell_value
  output logic [bcd_pkg::DATA_W-1:0]        m_axis_tdata_o,
  // deposited
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [bcd_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [bcd_pkg::DATA_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SIDE    = GRID_N + 1;
  localparam int unsigned DEPTH   = SIDE * SIDE;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COORD_W = $clog2(SIDE);
  localparam int unsigned DW      = bcd_pkg::DATA_W;
  localparam int unsigned MUL_W   = DW + 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LX    = 4'd2;
  localparam logic [3:0] ST_LZ    = 4'd3;
  localparam logic [3:0] ST_DN    = 4'd4;
  localparam logic [3:0] ST_J     = 4'd5;
  localparam logic [3:0] ST_CELL  = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;
  localparam logic [3:0] ST_MIR   = 4'd8;
  localparam logic [3:0] ST_RD    = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  localparam logic [ADDR_W-1:0]  SIDE_A = ADDR_W'(SIDE);
  localparam logic [ADDR_W-1:0]  N_A    = ADDR_W'(GRID_N);
  localparam logic [DW-1:0]      IDX_HI = DW'(GRID_N - 1);
  localparam logic [COORD_W:0]   N2_0   = (COORD_W+1)'(GRID_N);
  localparam logic [COORD_W:0]   N2_1   = (COORD_W+1)'(GRID_N - 1);
  localparam logic [COORD_W:0]   N2_2   = (COORD_W+1)'(GRID_N - 2);
  localparam logic [COORD_W-1:0] N_C    = COORD_W'(GRID_N);

  // configuration registers
  logic [DW-1:0] x_origin_q, z_origin_q, x_scale_q, z_scale_q, density_scale_q;
  logic          mirror_enable_q;

  // control state
  logic [3:0]        state_q, state_d;
  logic [1:0]        k_q, k_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic              ok_q;

  // request payload
  logic                kind_q;
  logic signed [DW:0]  dx_q, dz_q;
  logic [DW-1:0]       cur_q;
  logic [COORD_W-1:0]  col_q, row_q;
  logic                rd_ok_q;

  // locate results
  logic [2*DW-1:0]              prod_q;
  logic [COORD_W-1:0]           ix_q, iz_q;
  logic [bcd_pkg::FRAC_W-1:0]   fx_q, fz_q;
  logic                         okx_q, okz_q;
  logic signed [bcd_pkg::DENS_W-1:0] dens_q;
  logic [ADDR_W-1:0]            base_q, mbase_q;
  logic                         eq0_q, eq1_q, eq2_q;
  logic [DW-1:0]                val_q [4];

  // output register payload
  logic          out_dep_q;
  logic [DW-1:0] out_val_q;

  // combinational
  logic                    in_acc;
  logic [DW-1:0]           in_pos_x, in_pos_z, in_cur;
  logic [COORD_W-1:0]      in_col, in_row;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [DW-1:0]           loc_idx;
  logic                    loc_ok;
  logic [bcd_pkg::WGT_W-1:0] wx0, wz0;
  logic [ADDR_W-1:0]       cell_addr, mir_addr, rd_cell_addr;
  logic [3:0]              mir_hit;
  logic                    out_free, res_dep;
  logic [DW-1:0]           res_val;

  bcd_pkg::cell_req_t upd_req;
  bcd_pkg::cell_wr_t  upd_wr;
  logic               upd_rd_en, upd_busy;
  logic [ADDR_W-1:0]  upd_rd_addr, upd_waddr;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]     mem_wdata, mem_rdata;

  // request fields
  assign in_pos_x = s_axis_tdata_i[DW-1:0];
  assign in_pos_z = s_axis_tdata_i[2*DW-1:DW];
  assign in_cur   = s_axis_tdata_i[3*DW-1:2*DW];
  assign in_col   = s_axis_tdata_i[3*DW +: COORD_W];
  assign in_row   = s_axis_tdata_i[3*DW+COORD_W +: COORD_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q      <= '0;
      z_origin_q      <= '0;
      x_scale_q       <= DW'(32'h0001_0000);
      z_scale_q       <= DW'(32'h0001_0000);
      density_scale_q <= DW'(32'h0001_0000);
      mirror_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bcd_pkg::REG_X_ORIGIN:      x_origin_q      <= cfg_wdata_i;
        bcd_pkg::REG_Z_ORIGIN:      z_origin_q      <= cfg_wdata_i;
        bcd_pkg::REG_X_SCALE:       x_scale_q       <= cfg_wdata_i;
        bcd_pkg::REG_Z_SCALE:       z_scale_q       <= cfg_wdata_i;
        bcd_pkg::REG_DENSITY_SCALE: density_scale_q <= cfg_wdata_i;
        bcd_pkg::REG_MIRROR_ENABLE: mirror_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // shared locate / density multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LX: begin
        mul_a = $signed({1'b0, dx_q[DW-1:0]});
        mul_b = $signed({1'b0, x_scale_q});
      end
      ST_LZ: begin
        mul_a = $signed({1'b0, dz_q[DW-1:0]});
        mul_b = $signed({1'b0, z_scale_q});
      end
      ST_DN: begin
        mul_a = $signed({cur_q[DW-1], cur_q});
        mul_b = $signed({1'b0, density_scale_q});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // index check on the last product; distance must have been positive
  assign loc_idx = prod_q[2*DW-1:DW];

  always_comb begin
    if (state_q == ST_LZ) begin
      loc_ok = !dx_q[DW] && (dx_q != '0) && (loc_idx != '0) && (loc_idx <= IDX_HI);
    end else begin
      loc_ok = !dz_q[DW] && (dz_q != '0) && (loc_idx != '0) && (loc_idx <= IDX_HI);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[2*DW-1:0];
    if (in_acc) begin
      kind_q  <= s_axis_tuser_i;
      dx_q    <= $signed({in_pos_x[DW-1], in_pos_x}) - $signed({x_origin_q[DW-1], x_origin_q});
      dz_q    <= $signed({in_pos_z[DW-1], in_pos_z}) - $signed({z_origin_q[DW-1], z_origin_q});
      cur_q   <= in_cur;
      col_q   <= in_col;
      row_q   <= in_row;
      rd_ok_q <= (in_col <= N_C) && (in_row <= N_C);
    end
    if (state_q == ST_LZ) begin
      ix_q  <= loc_idx[COORD_W-1:0];
      fx_q  <= prod_q[DW-1:bcd_pkg::FRAC_W];
      okx_q <= loc_ok;
    end
    if (state_q == ST_DN) begin
      iz_q  <= loc_idx[COORD_W-1:0];
      fz_q  <= prod_q[DW-1:bcd_pkg::FRAC_W];
      okz_q <= loc_ok;
    end
    if (state_q == ST_J) begin
      dens_q  <= prod_q[bcd_pkg::FRAC_W +: bcd_pkg::DENS_W];
      base_q  <= ADDR_W'(ix_q) * SIDE_A + ADDR_W'(iz_q);
      mbase_q <= ADDR_W'(ix_q) * SIDE_A + N_A - ADDR_W'(iz_q);
      // mirror row equals iz, iz+1 or iz+2
      eq0_q   <= ({iz_q, 1'b0} == N2_0);
      eq1_q   <= ({iz_q, 1'b0} == N2_1);
      eq2_q   <= ({iz_q, 1'b0} == N2_2);
    end
    if (out_free && (state_q == ST_DONE)) begin
      out_dep_q <= res_dep;
      out_val_q <= res_val;
    end
  end

  // mirror copy k_q lands on deposited cell j (same column, same row)
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [1:0] jj;
      logic [1:0] rsum;
      jj   = 2'(j);
      rsum = {1'b0, jj[1]} + {1'b0, k_q[1]};
      mir_hit[j] = (jj[0] == k_q[0]) &&
                   (((rsum == 2'd0) && eq0_q) || ((rsum == 2'd1) && eq1_q) ||
                    ((rsum == 2'd2) && eq2_q));
    end
  end

  // values of the four deposited cells, tracked through the mirror copies
  always_ff @(posedge clk_i) begin
    if (upd_wr.valid) begin
      val_q[upd_wr.slot] <= upd_wr.value;
    end else if (state_q == ST_MIR) begin
      for (int j = 0; j < 4; j++) begin
        if (mir_hit[j]) begin
          val_q[j] <= val_q[k_q];
        end
      end
    end
  end

  // cell addresses and weights
  assign wx0          = bcd_pkg::WGT_ONE - {1'b0, fx_q};
  assign wz0          = bcd_pkg::WGT_ONE - {1'b0, fz_q};
  assign cell_addr    = base_q + (k_q[0] ? SIDE_A : '0) + (k_q[1] ? ADDR_W'(1) : '0);
  assign mir_addr     = mbase_q + (k_q[0] ? SIDE_A : '0) - (k_q[1] ? ADDR_W'(1) : '0);
  assign rd_cell_addr = ADDR_W'(col_q) * SIDE_A + ADDR_W'(row_q);

  assign upd_req.valid = (state_q == ST_CELL);
  assign upd_req.slot  = k_q;
  assign upd_req.wx    = k_q[0] ? {1'b0, fx_q} : wx0;
  assign upd_req.wz    = k_q[1] ? {1'b0, fz_q} : wz0;

  bcd_cell_update #(
    .ADDR_W(ADDR_W)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dens_i    (dens_q),
    .req_i     (upd_req),
    .req_addr_i(cell_addr),
    .rd_en_o   (upd_rd_en),
    .rd_addr_o (upd_rd_addr),
    .rd_data_i (mem_rdata),
    .wr_o      (upd_wr),
    .wr_addr_o (upd_waddr),
    .busy_o    (upd_busy)
  );

  // grid memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_MIR: begin
        mem_we    = 1'b1;
        mem_waddr = mir_addr;
        mem_wdata = val_q[k_q];
      end
      default: begin
        mem_we    = upd_wr.valid;
        mem_waddr = upd_waddr;
        mem_wdata = upd_wr.value;
      end
    endcase
  end

  assign mem_re    = upd_rd_en || (state_q == ST_RD);
  assign mem_raddr = (state_q == ST_RD) ? rd_cell_addr : upd_rd_addr;

  bcd_grid_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // result
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign res_dep  = (kind_q == bcd_pkg::KIND_DEPOSIT) && ok_q;
  assign res_val  = ((kind_q == bcd_pkg::KIND_READ) && rd_ok_q) ? mem_rdata : '0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser_i == bcd_pkg::KIND_READ) ? ST_RD : ST_LX;
        end
      end
      ST_LX:   state_d = ST_LZ;
      ST_LZ:   state_d = ST_DN;
      ST_DN:   state_d = ST_J;
      ST_J: begin
        k_d     = 2'd0;
        state_d = (okx_q && okz_q) ? ST_CELL : ST_DONE;
      end
      ST_CELL: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!upd_busy) begin
          state_d = mirror_enable_q ? ST_MIR : ST_DONE;
        end
      end
      ST_MIR: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_RD:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        ok_q <= 1'b0;
      end else if (state_q == ST_J) begin
        ok_q <= okx_q && okz_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_dep_q;

`ifndef SYNTH
  // nothing left in flight once the sequencer is back at idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mem_we && !upd_busy))
    else $error("grid write or cell update active while idle");

  // mirror copies only after an applied deposit, with the update pipeline empty
  a_mirror_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIR) |-> (ok_q && mirror_enable_q && !upd_busy))
    else $error("mirror copy without a finished deposit");

  // a deposit result never carries cell data
  a_dep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("deposit result with nonzero cell value");

  // a new result only comes out of the final sequencer step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done step");
`endif

endmodule
